// ===== rtl/mmix_pkg.sv =====
// ----------------------------------------------------------------------------
// mmix_pkg
// Shared types, constants and the control program of the motor mixer.
// ----------------------------------------------------------------------------
package mmix_pkg;

   localparam int NUM_MOTORS_DEF = 6;
   localparam int NUM_AXES       = 4;
   localparam int FRAC_BITS      = 14;

   localparam int PULSE_W  = 12;
   localparam int VALUE_W  = 16;
   localparam int OPCODE_W = 3;
   localparam int ROW_W    = 3;
   localparam int AXIS_W   = 2;
   localparam int MIDX_W   = 3;
   localparam int CSR_IDX_W = 2;

   // A sum of four 16x16 products, the scaled level and the lifted level.
   localparam int ACC_W  = 34;
   localparam int PROD_W = ACC_W + VALUE_W;
   localparam int LVL_W  = 48;

   localparam logic [PULSE_W-1:0] IDLE_PULSE_RST      = 12'd1000;
   localparam logic [PULSE_W-1:0] ARMED_MIN_PULSE_RST = 12'd1100;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST       = 12'd2000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ROLL      = 3'd0,
      OP_PITCH_MIX = 3'd1,
      OP_YAW       = 3'd2,
      OP_THRUST    = 3'd3,
      OP_ARM       = 3'd4,
      OP_LOAD_COEF = 3'd5
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_PULSE      = 2'd0,
      CSR_ARMED_MIN_PULSE = 2'd1,
      CSR_MAX_PULSE       = 2'd2
   } csr_index_type;

   localparam logic [AXIS_W-1:0] AXIS_ROLL   = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH  = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW    = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_THRUST = 2'd3;

   // Control word fields.
   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_COEF = 2'd1,
      MUL_SPAN = 2'd2
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT       = 2'd0,
      JMP_MLOOP      = 2'd1,
      JMP_MLOOP_END  = 2'd2,
      JMP_STOP       = 2'd3
   } jmp_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_MAC   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd8;

   typedef struct packed {
      mul_sel_type        mul;
      logic [AXIS_W-1:0]  axis;
      acc_op_type         acc;
      logic               lvl_wr;
      logic               lift_calc;
      logic               emit;
      logic               mot_step;
      jmp_type            jmp;
      logic [STEP_W-1:0]  target;
   } uword_type;

   localparam uword_type UW_NOP = '{
      mul: MUL_NONE, axis: AXIS_ROLL, acc: ACC_HOLD, lvl_wr: 1'b0, lift_calc: 1'b0,
      emit: 1'b0, mot_step: 1'b0, jmp: JMP_STOP, target: STEP_MAC
   };

   // Sequencer to datapath.
   typedef struct packed {
      uword_type          uw;
      logic [MIDX_W-1:0]  mot;
      logic               mot_first;
      logic               mot_last;
   } ctrl_type;

   // Top level to datapath: item decode.
   typedef struct packed {
      logic                      wr_demand;
      logic [AXIS_W-1:0]         demand_axis;
      logic                      wr_arm;
      logic                      wr_coef;
      logic [ROW_W-1:0]          coef_row;
      logic [AXIS_W-1:0]         coef_col;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [PULSE_W-1:0] idle_pulse;
      logic [PULSE_W-1:0] armed_min_pulse;
      logic [PULSE_W-1:0] max_pulse;
   } csr_type;

   typedef struct packed {
      logic               strobe;
      logic [MIDX_W-1:0]  motor_index;
      logic [PULSE_W-1:0] motor_command;
      logic               is_armed;
      logic               last_motor;
   } rsp_type;

   // Control program. Steps 0..6 run once per motor: four multiply-accumulates,
   // one scaling multiply and the level write. Step 7 forms the lift, step 8
   // emits one motor per pass.
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type uw;
      uw = UW_NOP;
      uw.jmp = JMP_NEXT;
      case (step)
         4'd0: begin
            uw.mul = MUL_COEF; uw.axis = AXIS_ROLL;
         end
         4'd1: begin
            uw.mul = MUL_COEF; uw.axis = AXIS_PITCH; uw.acc = ACC_LOAD;
         end
         4'd2: begin
            uw.mul = MUL_COEF; uw.axis = AXIS_YAW; uw.acc = ACC_ADD;
         end
         4'd3: begin
            uw.mul = MUL_COEF; uw.axis = AXIS_THRUST; uw.acc = ACC_ADD;
         end
         4'd4: begin
            uw.acc = ACC_ADD;
         end
         4'd5: begin
            uw.mul = MUL_SPAN;
         end
         4'd6: begin
            uw.lvl_wr = 1'b1; uw.mot_step = 1'b1; uw.jmp = JMP_MLOOP; uw.target = STEP_MAC;
         end
         4'd7: begin
            uw.lift_calc = 1'b1;
         end
         4'd8: begin
            uw.emit = 1'b1; uw.mot_step = 1'b1; uw.jmp = JMP_MLOOP_END;
            uw.target = STEP_EMIT;
         end
         default: begin
            uw = UW_NOP;
         end
      endcase
      return uw;
   endfunction

endpackage

// ===== rtl/mmix_ucode_seq.sv =====
// ----------------------------------------------------------------------------
// mmix_ucode_seq
// Step counter, control store and motor loop counter of the mixer.
// ----------------------------------------------------------------------------
module mmix_ucode_seq #(
   parameter int NUM_MOTORS = mmix_pkg::NUM_MOTORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_mix,
   output logic               busy,
   output mmix_pkg::ctrl_type ctrl
);
   import mmix_pkg::*;

   localparam int MOT_W = $clog2(NUM_MOTORS);

   logic              run_ff, run_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MOT_W-1:0]  mot_ff, mot_in;
   uword_type         uw;
   logic              mot_last;

   assign uw       = ucode_rom(step_ff);
   assign mot_last = (mot_ff == MOT_W'(NUM_MOTORS - 1));

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      mot_in  = mot_ff;
      if (start_mix) begin
         run_in  = 1'b1;
         step_in = STEP_MAC;
         mot_in  = '0;
      end else if (run_ff) begin
         if (uw.mot_step) begin
            mot_in = mot_last ? '0 : mot_ff + MOT_W'(1);
         end
         case (uw.jmp)
            JMP_NEXT: begin
               step_in = step_ff + STEP_W'(1);
            end
            JMP_MLOOP: begin
               step_in = mot_last ? step_ff + STEP_W'(1) : uw.target;
            end
            JMP_MLOOP_END: begin
               if (mot_last) begin
                  run_in = 1'b0;
               end else begin
                  step_in = uw.target;
               end
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= STEP_MAC;
         mot_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         mot_ff  <= mot_in;
      end
   end

   assign busy           = run_ff;
   assign ctrl.uw        = run_ff ? uw : UW_NOP;
   assign ctrl.mot       = MIDX_W'(mot_ff);
   assign ctrl.mot_first = (mot_ff == '0);
   assign ctrl.mot_last  = mot_last;

endmodule

// ===== rtl/mmix_datapath.sv =====
// ----------------------------------------------------------------------------
// mmix_datapath
// Demand and coefficient stores, shared multiplier, accumulator, level store,
// minimum tracking, lift and clamp, and the result register.
// ----------------------------------------------------------------------------
module mmix_datapath #(
   parameter int NUM_MOTORS = mmix_pkg::NUM_MOTORS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mmix_pkg::cmd_type  cmd,
   input  mmix_pkg::csr_type  csr,
   input  mmix_pkg::ctrl_type ctrl,
   output mmix_pkg::rsp_type  rsp
);
   import mmix_pkg::*;

   localparam int MOT_W = $clog2(NUM_MOTORS);

   logic signed [VALUE_W-1:0] demand_ff [NUM_AXES];
   logic signed [VALUE_W-1:0] mix_ff [NUM_MOTORS][NUM_AXES];
   logic                      armed_ff;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [LVL_W-1:0]   level_ff [NUM_MOTORS];
   logic signed [LVL_W-1:0]   min_ff;
   logic signed [LVL_W-1:0]   lift_ff;
   rsp_type                   rsp_ff;

   logic [MOT_W-1:0]          mot_idx;
   logic [MOT_W-1:0]          load_row;
   logic signed [ACC_W-1:0]   mul_a;
   logic signed [VALUE_W-1:0] mul_b;
   logic signed [PULSE_W:0]   span;
   logic signed [LVL_W-1:0]   lo_fix, hi_fix, new_level, out_level;
   logic [PULSE_W-1:0]        clamp_cmd;

   assign mot_idx  = ctrl.mot[MOT_W-1:0];
   assign load_row = cmd.coef_row[MOT_W-1:0];

   // Span may be negative when the armed range is inverted.
   assign span   = $signed({1'b0, csr.max_pulse}) - $signed({1'b0, csr.armed_min_pulse});
   assign lo_fix = $signed(LVL_W'(csr.armed_min_pulse)) <<< (2 * FRAC_BITS);
   assign hi_fix = $signed(LVL_W'(csr.max_pulse)) <<< (2 * FRAC_BITS);

   always_comb begin
      case (ctrl.uw.mul)
         MUL_COEF: begin
            mul_a = ACC_W'(mix_ff[mot_idx][ctrl.uw.axis]);
            mul_b = demand_ff[ctrl.uw.axis];
         end
         MUL_SPAN: begin
            mul_a = acc_ff;
            mul_b = VALUE_W'(span);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign new_level = LVL_W'(prod_ff) + lo_fix;
   assign out_level = level_ff[mot_idx] + lift_ff;

   always_comb begin
      if (out_level > hi_fix) begin
         clamp_cmd = csr.max_pulse;
      end else if (out_level < lo_fix) begin
         clamp_cmd = csr.armed_min_pulse;
      end else begin
         clamp_cmd = out_level[2 * FRAC_BITS +: PULSE_W];
      end
   end

   // Demand, arm and coefficient stores, written by the items.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            demand_ff[a] <= '0;
         end
         for (int m = 0; m < NUM_MOTORS; m++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               mix_ff[m][a] <= '0;
            end
         end
      end else begin
         if (cmd.wr_demand) begin
            demand_ff[cmd.demand_axis] <= cmd.value;
         end
         if (cmd.wr_arm) begin
            armed_ff <= (cmd.value != '0);
         end
         if (cmd.wr_coef) begin
            mix_ff[load_row][cmd.coef_col] <= cmd.value;
         end
      end
   end

   // Arithmetic pipeline, driven by the control word.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (ctrl.uw.acc)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
      if (ctrl.uw.lvl_wr) begin
         level_ff[mot_idx] <= new_level;
         if (ctrl.mot_first || (new_level < min_ff)) begin
            min_ff <= new_level;
         end
      end
      if (ctrl.uw.lift_calc) begin
         lift_ff <= (min_ff < lo_fix) ? lo_fix - min_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= ctrl.uw.emit;
      end
      if (ctrl.uw.emit) begin
         rsp_ff.motor_index   <= ctrl.mot;
         rsp_ff.motor_command <= armed_ff ? clamp_cmd : csr.idle_pulse;
         rsp_ff.is_armed      <= armed_ff;
         rsp_ff.last_motor    <= ctrl.mot_last;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/multirotor_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// multirotor_motor_mixer
// Fixed-point motor mixer: stores axis demands and mixing coefficients and,
// on a pitch item, produces one pulse command per motor (clamped when armed).
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. Roll, yaw,
//   thrust, arm and coefficient-load items finish in that edge, emit nothing
//   and leave busy low, so another item can follow in the next cycle.
//   A pitch item stores pitch and starts the mix; busy is high while it runs.
//   Each motor takes seven steps of the sequencer on the one shared multiplier
//   (four multiply-accumulates, one scaling multiply, one level write), then
//   one step forms the lift and one step per motor emits a result.
//   Results come one beat per cycle on the rsp_ ports, marked by rsp_strobe,
//   motor 0 first; rsp_last_motor marks the final beat, which shows in the cycle
//   in which busy has just dropped. The receiver cannot stall the result beats.
//   The user must write registers through the csr_ port only while busy is low;
//   the block does not enforce it. Synchronous reset clears demands, the arm
//   flag and all coefficients and loads the register reset values.
// ----------------------------------------------------------------------------
module multirotor_motor_mixer #(
   parameter int NUM_MOTORS = mmix_pkg::NUM_MOTORS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [mmix_pkg::OPCODE_W-1:0]          req_opcode,
   input  logic signed [mmix_pkg::VALUE_W-1:0]    req_value,
   input  logic [mmix_pkg::ROW_W-1:0]             req_coef_row,
   input  logic [mmix_pkg::AXIS_W-1:0]            req_coef_col,
   output logic                                   rsp_strobe,
   output logic [mmix_pkg::MIDX_W-1:0]            rsp_motor_index,
   output logic [mmix_pkg::PULSE_W-1:0]           rsp_motor_command,
   output logic                                   rsp_is_armed,
   output logic                                   rsp_last_motor,
   input  logic                                   csr_write_enable,
   input  logic [mmix_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mmix_pkg::PULSE_W-1:0]           csr_write_data
);
   import mmix_pkg::*;

   csr_type  csr_ff;
   cmd_type  cmd;
   ctrl_type ctrl;
   rsp_type  rsp;
   logic     accept;
   logic     start_mix;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.idle_pulse      <= IDLE_PULSE_RST;
         csr_ff.armed_min_pulse <= ARMED_MIN_PULSE_RST;
         csr_ff.max_pulse       <= MAX_PULSE_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IDLE_PULSE:      csr_ff.idle_pulse      <= csr_write_data;
            CSR_ARMED_MIN_PULSE: csr_ff.armed_min_pulse <= csr_write_data;
            CSR_MAX_PULSE:       csr_ff.max_pulse       <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign accept = start && !busy;

   always_comb begin
      cmd.wr_demand   = 1'b0;
      cmd.demand_axis = AXIS_ROLL;
      cmd.wr_arm      = 1'b0;
      cmd.wr_coef     = 1'b0;
      cmd.coef_row    = req_coef_row;
      cmd.coef_col    = req_coef_col;
      cmd.value       = req_value;
      start_mix       = 1'b0;
      if (accept) begin
         case (opcode_type'(req_opcode))
            OP_ROLL: begin
               cmd.wr_demand = 1'b1; cmd.demand_axis = AXIS_ROLL;
            end
            OP_PITCH_MIX: begin
               cmd.wr_demand = 1'b1; cmd.demand_axis = AXIS_PITCH; start_mix = 1'b1;
            end
            OP_YAW: begin
               cmd.wr_demand = 1'b1; cmd.demand_axis = AXIS_YAW;
            end
            OP_THRUST: begin
               cmd.wr_demand = 1'b1; cmd.demand_axis = AXIS_THRUST;
            end
            OP_ARM: begin
               cmd.wr_arm = 1'b1;
            end
            OP_LOAD_COEF: begin
               // Rows beyond the last motor are dropped.
               cmd.wr_coef = (32'(req_coef_row) < NUM_MOTORS);
            end
            default: begin
            end
         endcase
      end
   end

   mmix_ucode_seq #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start_mix (start_mix),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   mmix_datapath #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .csr   (csr_ff),
      .ctrl  (ctrl),
      .rsp   (rsp)
   );

   assign rsp_strobe        = rsp.strobe;
   assign rsp_motor_index   = rsp.motor_index;
   assign rsp_motor_command = rsp.motor_command;
   assign rsp_is_armed      = rsp.is_armed;
   assign rsp_last_motor    = rsp.last_motor;

`ifndef SYNTHESIS
   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset)) |-> $past(busy))
      else $error("result beat without a running mix");

   a_mix_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_PITCH_MIX) |=> busy)
      else $error("pitch item did not start the mix");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_motor) |-> (rsp_motor_index == MIDX_W'(NUM_MOTORS - 1)))
      else $error("last beat on the wrong motor");

   a_end_with_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_last_motor))
      else $error("mix ended without its last beat");
`endif

endmodule
